[src/qau_pkg.sv]
`default_nettype none
package qau_pkg;

  // number format
  localparam int DW = 32;
  localparam int FB = 16;

  // internal widths
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 2;
  localparam int TW   = SW - FB;
  localparam int CW   = DW + 1;
  localparam int TL   = TW / 2;
  localparam int TH   = TW - TL;
  localparam int RW   = TW + CW;
  localparam int RSW  = RW + 2;
  localparam int QW   = SW / 2;
  localparam int NW   = 2 * QW;
  localparam int DENW = PW + 1;
  localparam int NUMW = ((DW + 2 * FB > PW) ? DW + 2 * FB : PW) + 1;
  localparam int SHW  = DENW + DW;
  localparam int XW   = RSW;

  // pipeline depths
  localparam int EARLY_LAT = 7;
  localparam int TOTAL_LAT = 2 + QW + 1 + DW + 1;
  localparam int DLY       = TOTAL_LAT - EARLY_LAT;

  // operation codes
  localparam logic [2:0] FN_MUL  = 3'd0;
  localparam logic [2:0] FN_ROT  = 3'd1;
  localparam logic [2:0] FN_DOT  = 3'd2;
  localparam logic [2:0] FN_CONJ = 3'd3;
  localparam logic [2:0] FN_NORM = 3'd4;
  localparam logic [2:0] FN_INV  = 3'd5;

  typedef logic signed [DW-1:0]     word_t;
  typedef logic signed [CW-1:0]     cword_t;
  typedef logic signed [TW-1:0]     twide_t;
  typedef logic signed [RSW-FB-1:0] rwide_t;

  localparam word_t WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [2:0] func;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      a_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      b_w;
  } operand_t;

  typedef struct packed {
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_w;
    logic  zero_norm;
    logic  saturated;
  } result_t;

  typedef struct packed {
    word_t v;
    logic  s;
  } clamp_t;

  // front end to square root
  typedef struct packed {
    logic [2:0]  func;
    word_t [3:0] a;
    logic [SW-1:0] n2;
  } nrm_t;

  // front end to rotate back end
  typedef struct packed {
    logic [2:0]   func;
    twide_t [3:0] t;
    cword_t [3:0] c;
    result_t      early;
  } rot_t;

  // square root to divider
  typedef struct packed {
    logic [2:0]    func;
    word_t [3:0]   a;
    logic [SW-1:0] n2;
    logic [QW-1:0] root;
  } sq_t;

  // result tagged with its operation
  typedef struct packed {
    logic [2:0] func;
    result_t    res;
  } early_t;

  // one divider step
  typedef struct packed {
    logic [2:0]             func;
    logic                   zn;
    logic [DENW-1:0]        den;
    logic [3:0]             neg;
    logic [3:0]             ovf;
    logic [3:0][NUMW-1:0]   rem;
    logic [3:0][DW-1:0]     q;
  } dstep_t;

  // saturate a wide value to one word
  function automatic clamp_t clampw(input logic signed [XW-1:0] v);
    clamp_t r;
    if (v[XW-1:DW-1] == {(XW-DW+1){v[XW-1]}}) begin
      r.v = v[DW-1:0];
      r.s = 1'b0;
    end else begin
      r.v = v[XW-1] ? WMIN : WMAX;
      r.s = 1'b1;
    end
    return r;
  endfunction

  // round half up and drop the fraction, first product sums
  function automatic twide_t rnd_sum(input logic signed [SW-1:0] v);
    logic [SW-1:0] s;
    s = v + (SW'(1) << (FB - 1));
    return s[SW-1:FB];
  endfunction

  // same for the rotate back end sums
  function automatic rwide_t rnd_rot(input logic signed [RSW-1:0] v);
    logic [RSW-1:0] s;
    s = v + (RSW'(1) << (FB - 1));
    return s[RSW-1:FB];
  endfunction

endpackage
`default_nettype wire

[src/qau_front.sv]
`default_nettype none
module qau_front import qau_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire operand_t operand,
  output logic          nrm_valid,
  output nrm_t          nrm,
  output rot_t          rot
);

  word_t [3:0] a;
  word_t [3:0] b;
  logic signed [PW-1:0] prod [4][4];
  logic signed [PW-1:0] sq [4];
  logic [2:0]  func1;
  word_t [3:0] a1;
  logic        valid1;
  logic signed [SW-1:0] o [4];
  logic signed [SW-1:0] dot;
  logic signed [SW-1:0] n2;
  logic [2:0]  func2;
  word_t [3:0] a2;
  logic        valid2;
  cword_t [3:0] c;
  clamp_t mc [4];
  clamp_t cc [4];
  clamp_t dc;
  result_t fast;

  // operand unpack, rotate treats b as a pure vector
  always_comb begin
    a[0] = operand.a_x;
    a[1] = operand.a_y;
    a[2] = operand.a_z;
    a[3] = operand.a_w;
    b[0] = operand.b_x;
    b[1] = operand.b_y;
    b[2] = operand.b_z;
    b[3] = (operand.func == FN_ROT) ? '0 : operand.b_w;
  end

  // stage 1: all cross products and squares
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= start;
    end
    func1 <= operand.func;
    a1    <= a;
    for (int i = 0; i < 4; i++) begin
      sq[i] <= $signed(a[i]) * $signed(a[i]);
      for (int j = 0; j < 4; j++) begin
        prod[i][j] <= $signed(a[i]) * $signed(b[j]);
      end
    end
  end

  // stage 2: hamilton sums, dot product, squared norm
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
    func2 <= func1;
    a2    <= a1;
    o[0] <= SW'(prod[1][2]) - SW'(prod[2][1]) + SW'(prod[3][0]) + SW'(prod[0][3]);
    o[1] <= SW'(prod[2][0]) - SW'(prod[0][2]) + SW'(prod[3][1]) + SW'(prod[1][3]);
    o[2] <= SW'(prod[0][1]) - SW'(prod[1][0]) + SW'(prod[3][2]) + SW'(prod[2][3]);
    o[3] <= SW'(prod[3][3]) - SW'(prod[0][0]) - SW'(prod[1][1]) - SW'(prod[2][2]);
    dot  <= SW'(prod[0][0]) + SW'(prod[1][1]) + SW'(prod[2][2]) + SW'(prod[3][3]);
    n2   <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
  end

  // stage 3 logic: round and saturate the short operations
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      c[i] = CW'($signed(a2[i]));
      if (i < 3) begin
        c[i] = -c[i];
      end
      mc[i] = clampw(XW'(rnd_sum(o[i])));
      cc[i] = clampw(XW'($signed(c[i])));
    end
    dc = clampw(XW'(rnd_sum(dot)));
    fast = '0;
    case (func2)
      FN_MUL: begin
        fast.r_x = mc[0].v;
        fast.r_y = mc[1].v;
        fast.r_z = mc[2].v;
        fast.r_w = mc[3].v;
        fast.saturated = mc[0].s | mc[1].s | mc[2].s | mc[3].s;
      end
      FN_DOT: begin
        fast.r_w = dc.v;
        fast.saturated = dc.s;
      end
      FN_CONJ: begin
        fast.r_x = cc[0].v;
        fast.r_y = cc[1].v;
        fast.r_z = cc[2].v;
        fast.r_w = cc[3].v;
        fast.saturated = cc[0].s | cc[1].s | cc[2].s | cc[3].s;
      end
      default: begin
        fast = '0;
      end
    endcase
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    rot.func  <= func2;
    rot.c     <= c;
    rot.early <= fast;
    for (int i = 0; i < 4; i++) begin
      rot.t[i] <= rnd_sum(o[i]);
    end
  end

  // norm path leaves after stage 2
  always_comb begin
    nrm.func  = func2;
    nrm.a     = a2;
    nrm.n2    = n2;
    nrm_valid = valid2;
  end

endmodule
`default_nettype wire

[src/qau_rot.sv]
`default_nettype none
module qau_rot import qau_pkg::*; (
  input  wire       clk,
  input  wire rot_t rin,
  output early_t    eout
);

  logic signed [TL+CW:0]   pl [4][4];
  logic signed [TH+CW-1:0] ph [4][4];
  logic signed [RW-1:0]    fp [4][4];
  logic signed [RSW-1:0]   o [4];
  clamp_t rc [3];
  logic [2:0] func4;
  logic [2:0] func5;
  logic [2:0] func6;
  result_t early4;
  result_t early5;
  result_t early6;

  // stage 4: split partial products of t by conj(a)
  always_ff @(posedge clk) begin
    func4  <= rin.func;
    early4 <= rin.early;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pl[i][j] <= $signed({1'b0, rin.t[i][TL-1:0]}) * $signed(rin.c[j]);
        ph[i][j] <= $signed(rin.t[i][TW-1:TL]) * $signed(rin.c[j]);
      end
    end
  end

  // stage 5: recombine halves
  always_ff @(posedge clk) begin
    func5  <= func4;
    early5 <= early4;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        fp[i][j] <= (RW'(ph[i][j]) <<< TL) + RW'(pl[i][j]);
      end
    end
  end

  // stage 6: hamilton sums for the vector part
  always_ff @(posedge clk) begin
    func6  <= func5;
    early6 <= early5;
    o[0] <= RSW'(fp[1][2]) - RSW'(fp[2][1]) + RSW'(fp[3][0]) + RSW'(fp[0][3]);
    o[1] <= RSW'(fp[2][0]) - RSW'(fp[0][2]) + RSW'(fp[3][1]) + RSW'(fp[1][3]);
    o[2] <= RSW'(fp[0][1]) - RSW'(fp[1][0]) + RSW'(fp[3][2]) + RSW'(fp[2][3]);
    o[3] <= '0;
  end

  // stage 7 logic: round and saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rc[i] = clampw(XW'(rnd_rot(o[i])));
    end
  end

  // stage 7: pick rotate or carried result
  always_ff @(posedge clk) begin
    eout.func <= func6;
    if (func6 == FN_ROT) begin
      eout.res.r_x       <= rc[0].v;
      eout.res.r_y       <= rc[1].v;
      eout.res.r_z       <= rc[2].v;
      eout.res.r_w       <= o[3][DW-1:0];
      eout.res.zero_norm <= 1'b0;
      eout.res.saturated <= rc[0].s | rc[1].s | rc[2].s;
    end else begin
      eout.res <= early6;
    end
  end

endmodule
`default_nettype wire

[src/qau_sqrt.sv]
`default_nettype none
module qau_sqrt import qau_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  input  wire       nin_valid,
  input  wire nrm_t nin,
  output logic      sout_valid,
  output sq_t       sout
);

  logic [QW+1:0] rem [QW];
  logic [QW-1:0] root [QW];
  nrm_t          pay [QW];
  logic          vld [QW];

  // one root bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW+1:0] rem_in;
    logic [QW-1:0] root_in;
    nrm_t          pay_in;
    logic          vld_in;
    logic [QW+3:0] rx;
    logic [QW+3:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = nin;
      assign vld_in  = nin_valid;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign pay_in  = pay[k-1];
      assign vld_in  = vld[k-1];
    end

    // bring down two bits and form the trial subtrahend
    always_comb begin
      rx    = {rem_in, pay_in.n2[NW-1-2*k -: 2]};
      trial = {2'b00, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_in;
      end
      pay[k] <= pay_in;
      if (rx >= trial) begin
        rem[k]  <= (QW+2)'(rx - trial);
        root[k] <= {root_in[QW-2:0], 1'b1};
      end else begin
        rem[k]  <= rx[QW+1:0];
        root[k] <= {root_in[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sout.func  = pay[QW-1].func;
    sout.a     = pay[QW-1].a;
    sout.n2    = pay[QW-1].n2;
    sout.root  = root[QW-1];
    sout_valid = vld[QW-1];
  end

endmodule
`default_nettype wire

[src/qau_div.sv]
`default_nettype none
module qau_div import qau_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  wire      sin_valid,
  input  wire sq_t sin,
  output logic     dout_valid,
  output early_t   dout
);

  logic [DENW-1:0] den0;
  cword_t          mag [4];
  logic [NUMW-1:0] num [4];
  logic [3:0]      neg0;
  logic [3:0]      ovf0;
  dstep_t          st [DW+1];
  logic            sv [DW+1];
  cword_t          qs [4];
  clamp_t          qc [4];
  word_t           fv [4];
  logic [3:0]      fs;

  // divisor select, rounded numerator magnitude, overflow check
  always_comb begin
    den0 = (sin.func == FN_NORM) ? DENW'(sin.root) : DENW'(sin.n2);
    for (int i = 0; i < 4; i++) begin
      mag[i] = sin.a[i][DW-1] ? -CW'($signed(sin.a[i])) : CW'($signed(sin.a[i]));
      if (sin.func == FN_NORM) begin
        num[i]  = NUMW'(mag[i][DW-1:0]) << FB;
        neg0[i] = sin.a[i][DW-1];
      end else begin
        num[i] = NUMW'(mag[i][DW-1:0]) << (2 * FB);
        if (i < 3) begin
          neg0[i] = !sin.a[i][DW-1] && (sin.a[i] != '0);
        end else begin
          neg0[i] = sin.a[i][DW-1];
        end
      end
      num[i]  = num[i] + NUMW'(den0 >> 1);
      ovf0[i] = SHW'(num[i]) >= (SHW'(den0) << DW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= sin_valid;
    end
    st[0].func <= sin.func;
    st[0].zn   <= (sin.n2 == '0);
    st[0].den  <= den0;
    st[0].neg  <= neg0;
    st[0].ovf  <= ovf0;
    st[0].q    <= '0;
    for (int i = 0; i < 4; i++) begin
      st[0].rem[i] <= num[i];
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < DW; k++) begin : g_step
    localparam int B = DW - 1 - k;
    logic [SHW-1:0] dsh;
    logic [3:0]     take;
    dstep_t         step_next;

    always_comb begin
      dsh       = SHW'(st[k].den) << B;
      step_next = st[k];
      for (int i = 0; i < 4; i++) begin
        take[i] = SHW'(st[k].rem[i]) >= dsh;
        if (take[i]) begin
          step_next.rem[i] = NUMW'(SHW'(st[k].rem[i]) - dsh);
        end
        step_next.q[i] = {st[k].q[i][DW-2:0], take[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= sv[k];
      end
      st[k+1] <= step_next;
    end
  end

  // apply sign, saturate, zero norm
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qs[i] = CW'(st[DW].q[i]);
      if (st[DW].neg[i]) begin
        qs[i] = -qs[i];
      end
      qc[i] = clampw(XW'($signed(qs[i])));
      if (st[DW].zn) begin
        fv[i] = '0;
        fs[i] = 1'b0;
      end else if (st[DW].ovf[i]) begin
        fv[i] = st[DW].neg[i] ? WMIN : WMAX;
        fs[i] = 1'b1;
      end else begin
        fv[i] = qc[i].v;
        fs[i] = qc[i].s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else begin
      dout_valid <= sv[DW];
    end
    dout.func          <= st[DW].func;
    dout.res.r_x       <= fv[0];
    dout.res.r_y       <= fv[1];
    dout.res.r_z       <= fv[2];
    dout.res.r_w       <= fv[3];
    dout.res.zero_norm <= st[DW].zn;
    dout.res.saturated <= |fs;
  end

endmodule
`default_nettype wire

[src/quaternion_arithmetic_unit.sv]
`default_nettype none
// Quaternion arithmetic unit, signed Q16.16, no state between items.
// Input: an item (func plus quaternions a and b) is taken on a rising edge
// with start high and busy low. busy is always low: the unit is fully
// pipelined and takes a new item every cycle.
// Output: each item yields one result on result, qualified by done for one
// cycle, in input order. The short paths (multiply, dot, conjugate) finish in
// the front end and the rotate path in the rotate back end, then wait in a
// delay line for the normalize/inverse path, which is the product and sum
// stages, 33 square root stages, 1 setup stage, 32 divider stages and an
// output stage.
// Throughput: one item per cycle.
// Reset: synchronous rst clears all valid bits; items in flight are dropped
// and done stays low until a new item has passed through.
// The receiver cannot stall: results must be taken in the cycle done is high.
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire operand_t operand,
  output logic          busy,
  output logic          done,
  output result_t       result
);

  logic   nrm_valid;
  nrm_t   nrm;
  rot_t   rot;
  early_t early;
  logic   sq_valid;
  sq_t    sq;
  logic   div_valid;
  early_t div_out;
  early_t dl [DLY];

  assign busy = 1'b0;

  qau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operand   (operand),
    .nrm_valid (nrm_valid),
    .nrm       (nrm),
    .rot       (rot)
  );

  qau_rot u_rot (
    .clk  (clk),
    .rin  (rot),
    .eout (early)
  );

  qau_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .nin_valid  (nrm_valid),
    .nin        (nrm),
    .sout_valid (sq_valid),
    .sout       (sq)
  );

  qau_div u_div (
    .clk        (clk),
    .rst        (rst),
    .sin_valid  (sq_valid),
    .sin        (sq),
    .dout_valid (div_valid),
    .dout       (div_out)
  );

  // align short results with the divider output
  always_ff @(posedge clk) begin
    dl[0] <= early;
    for (int i = 1; i < DLY; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  // final select
  always_comb begin
    done = div_valid;
    if (dl[DLY-1].func == FN_NORM || dl[DLY-1].func == FN_INV) begin
      result = div_out.res;
    end else begin
      result = dl[DLY-1].res;
    end
  end

endmodule
`default_nettype wire

[sim/tb_quaternion_arithmetic_unit.sv]
`timescale 1ns / 1ps
module tb_quaternion_arithmetic_unit;
  import qau_pkg::*;

  typedef logic signed [191:0] big_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 850;
  localparam int DRAIN_CYCLES   = TOTAL_LAT + 20;

  logic     clk;
  logic     rst;
  logic     start;
  operand_t operand;
  logic     busy;
  logic     done;
  result_t  result;

  quaternion_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .operand(operand),
    .busy(busy), .done(done), .result(result)
  );

  // expected results, oldest first
  result_t pending_results[$];
  int      error_count = 0;
  int      item_count = 0;
  int      result_count = 0;
  int      idle_cycles = 0;
  int      func_hits[8];

  // directed stimulus table
  typedef struct {
    operand_t op;
    bit       typed;
    result_t  want;
  } row_t;
  row_t table_rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixed point helpers for the quaternion predictor
  function automatic big_t round_frac(input big_t v);
    return (v + big_t'(32768)) >>> FB;
  endfunction

  function automatic word_t sat_word(input big_t v, inout bit sat);
    if (v > big_t'(WMAX)) begin
      sat = 1'b1;
      return WMAX;
    end else if (v < big_t'(WMIN)) begin
      sat = 1'b1;
      return WMIN;
    end
    return v[DW-1:0];
  endfunction

  function automatic big_t sat_64(input big_t v, inout bit sat);
    big_t hi;
    big_t lo;
    hi = (big_t'(1) <<< 63) - 1;
    lo = -(big_t'(1) <<< 63);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end else if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void hamilton(input big_t p[4], input big_t q[4], output big_t o[4]);
    o[0] = p[1]*q[2] - p[2]*q[1] + q[0]*p[3] + p[0]*q[3];
    o[1] = p[2]*q[0] - p[0]*q[2] + q[1]*p[3] + p[1]*q[3];
    o[2] = p[0]*q[1] - p[1]*q[0] + q[2]*p[3] + p[2]*q[3];
    o[3] = p[3]*q[3] - p[0]*q[0] - p[1]*q[1] - p[2]*q[2];
  endfunction

  function automatic big_t floor_sqrt(input big_t n);
    big_t root;
    big_t cand;
    root = 0;
    for (int k = 40; k >= 0; k--) begin
      cand = root | (big_t'(1) <<< k);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic big_t div_nearest(input big_t num, input big_t den);
    big_t mag;
    big_t quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + (den >>> 1)) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  // expected result of one quaternion operation
  function automatic result_t quat_predict(input operand_t op);
    result_t r;
    big_t a[4], b[4], c[4], o[4], t[4];
    big_t n2, den, num;
    bit sat;
    r = '0;
    sat = 1'b0;
    a[0] = op.a_x; a[1] = op.a_y; a[2] = op.a_z; a[3] = op.a_w;
    b[0] = op.b_x; b[1] = op.b_y; b[2] = op.b_z; b[3] = op.b_w;
    for (int i = 0; i < 4; i++) c[i] = (i < 3) ? -a[i] : a[i];
    n2 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
    case (op.func)
      FN_MUL: begin
        hamilton(a, b, o);
        r.r_x = sat_word(round_frac(o[0]), sat);
        r.r_y = sat_word(round_frac(o[1]), sat);
        r.r_z = sat_word(round_frac(o[2]), sat);
        r.r_w = sat_word(round_frac(o[3]), sat);
      end
      FN_ROT: begin
        b[3] = 0;
        hamilton(a, b, o);
        for (int i = 0; i < 4; i++) t[i] = sat_64(round_frac(o[i]), sat);
        hamilton(t, c, o);
        r.r_x = sat_word(round_frac(o[0]), sat);
        r.r_y = sat_word(round_frac(o[1]), sat);
        r.r_z = sat_word(round_frac(o[2]), sat);
      end
      FN_DOT: begin
        r.r_w = sat_word(round_frac(a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]), sat);
      end
      FN_CONJ: begin
        r.r_x = sat_word(c[0], sat);
        r.r_y = sat_word(c[1], sat);
        r.r_z = sat_word(c[2], sat);
        r.r_w = sat_word(c[3], sat);
      end
      FN_NORM, FN_INV: begin
        if (n2 == 0) begin
          r.zero_norm = 1'b1;
        end else begin
          den = (op.func == FN_NORM) ? floor_sqrt(n2) : n2;
          for (int i = 0; i < 4; i++) begin
            num = (op.func == FN_NORM) ? (a[i] <<< FB) : (c[i] <<< (2 * FB));
            o[i] = div_nearest(num, den);
          end
          r.r_x = sat_word(o[0], sat);
          r.r_y = sat_word(o[1], sat);
          r.r_z = sat_word(o[2], sat);
          r.r_w = sat_word(o[3], sat);
        end
      end
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    error_count++;
  endtask

  // random word biased toward interesting magnitudes
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return WMAX;
      1: return WMIN;
      2: return word_t'(0);
      3, 4: return word_t'($signed($urandom_range(0, 262143)) - 131072);
      5: return word_t'($signed($urandom_range(0, 33554431)) - 16777216);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic operand_t rand_operand();
    operand_t op;
    op.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
    op.a_x = rand_word(); op.a_y = rand_word(); op.a_z = rand_word(); op.a_w = rand_word();
    op.b_x = rand_word(); op.b_y = rand_word(); op.b_z = rand_word(); op.b_w = rand_word();
    // occasional all-zero a to hit the zero norm path
    if ($urandom_range(0, 24) == 0) begin
      op.a_x = '0; op.a_y = '0; op.a_z = '0; op.a_w = '0;
    end
    return op;
  endfunction

  function automatic operand_t mk_op(input logic [2:0] f, input word_t ax, input word_t ay,
                                     input word_t az, input word_t aw, input word_t bx,
                                     input word_t by, input word_t bz, input word_t bw);
    operand_t op;
    op.func = f;
    op.a_x = ax; op.a_y = ay; op.a_z = az; op.a_w = aw;
    op.b_x = bx; op.b_y = by; op.b_z = bz; op.b_w = bw;
    return op;
  endfunction

  function automatic result_t mk_res(input word_t x, input word_t y, input word_t z,
                                     input word_t w, input logic zn, input logic sat);
    result_t r;
    r.r_x = x; r.r_y = y; r.r_z = z; r.r_w = w;
    r.zero_norm = zn; r.saturated = sat;
    return r;
  endfunction

  task automatic add_row(input operand_t op, input bit typed, input result_t want);
    row_t row;
    row.op = op;
    row.typed = typed;
    row.want = want;
    table_rows.push_back(row);
  endtask

  // present one item, after an optional gap, and wait for it to be taken
  task automatic send_item(input operand_t op, input int gap, input bit typed,
                           input result_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    operand <= op;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? want : quat_predict(op));
    func_hits[op.func]++;
    item_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result.r_x, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (result.r_x !== want.r_x) report_mismatch("r_x", result.r_x, want.r_x);
        if (result.r_y !== want.r_y) report_mismatch("r_y", result.r_y, want.r_y);
        if (result.r_z !== want.r_z) report_mismatch("r_z", result.r_z, want.r_z);
        if (result.r_w !== want.r_w) report_mismatch("r_w", result.r_w, want.r_w);
        if (result.zero_norm !== want.zero_norm)
          report_mismatch("zero_norm", 32'(result.zero_norm), 32'(want.zero_norm));
        if (result.saturated !== want.saturated)
          report_mismatch("saturated", 32'(result.saturated), 32'(want.saturated));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    word_t one_q;
    word_t two_q;
    int    gap;
    int    idle_pct;
    result_t none;
    one_q = 32'sh0001_0000;
    two_q = 32'sh0002_0000;
    none = '0;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows: typed where the answer is plain
    add_row(mk_op(FN_CONJ, one_q, two_q, -one_q, two_q, 0, 0, 0, 0), 1,
            mk_res(-one_q, -two_q, one_q, two_q, 0, 0));
    add_row(mk_op(FN_CONJ, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0), 1,
            mk_res(WMAX, WMAX, WMAX, WMIN, 0, 1));
    add_row(mk_op(FN_NORM, 0, 0, 0, 0, WMAX, WMIN, 1, 2), 1, mk_res(0, 0, 0, 0, 1, 0));
    add_row(mk_op(FN_INV, 0, 0, 0, 0, 5, 6, 7, 8), 1, mk_res(0, 0, 0, 0, 1, 0));
    add_row(mk_op(3'd6, WMAX, WMIN, 1, 2, 3, 4, 5, 6), 1, none);
    add_row(mk_op(3'd7, WMIN, WMAX, -1, -2, -3, -4, -5, -6), 1, none);
    add_row(mk_op(FN_MUL, 0, 0, 0, one_q, 32'sh1234, -32'sh5678, WMAX, WMIN), 1,
            mk_res(32'sh1234, -32'sh5678, WMAX, WMIN, 0, 0));
    add_row(mk_op(FN_NORM, 0, 0, 0, two_q, 0, 0, 0, 0), 1, mk_res(0, 0, 0, one_q, 0, 0));
    add_row(mk_op(FN_INV, 0, 0, 0, two_q, 0, 0, 0, 0), 1,
            mk_res(0, 0, 0, 32'sh8000, 0, 0));
    add_row(mk_op(FN_MUL, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 0, none);
    add_row(mk_op(FN_MUL, WMIN, WMIN, WMIN, WMIN, WMAX, WMIN, WMAX, WMIN), 0, none);
    add_row(mk_op(FN_ROT, WMIN, WMAX, WMIN, WMAX, WMAX, WMIN, WMAX, WMIN), 0, none);
    add_row(mk_op(FN_ROT, 0, 0, 32'sh0000_B505, 32'sh0000_B505, one_q, 0, 0, WMAX), 0, none);
    add_row(mk_op(FN_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX), 0, none);
    add_row(mk_op(FN_DOT, WMIN, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMAX), 0, none);
    add_row(mk_op(FN_DOT, one_q, -one_q, 3, -7, -32'sh8000, 32'sh8000, 1, 1), 0, none);
    add_row(mk_op(FN_NORM, WMIN, WMIN, WMIN, WMIN, 0, 0, 0, 0), 0, none);
    add_row(mk_op(FN_NORM, 0, 0, 0, 1, 0, 0, 0, 0), 0, none);
    add_row(mk_op(FN_NORM, WMAX, -1, 1, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_op(FN_INV, 0, 1, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_op(FN_INV, WMAX, WMIN, WMAX, WMIN, 0, 0, 0, 0), 0, none);
    add_row(mk_op(FN_INV, 0, 0, 0, -32'sh0000_4000, 0, 0, 0, 0), 0, none);

    foreach (table_rows[i]) send_item(table_rows[i].op, 0, table_rows[i].typed,
                                      table_rows[i].want);

    // random items in phases of sender idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n * 4) / RANDOM_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 63;
        2: idle_pct = 0;
        default: idle_pct = 34;
      endcase
      // each cycle is idle with the phase probability
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      // hold off once until the pipe has emptied
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        gap = 0;
      end
      send_item(rand_operand(), gap, 0, none);
    end
    start <= 1'b0;

    // drain and let any stray result show up
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d results: mul %0d rot %0d dot %0d conj %0d",
             item_count, result_count, func_hits[0], func_hits[1], func_hits[2],
             func_hits[3]);
    $display("normalize %0d inverse %0d unused selector %0d, mismatches %0d",
             func_hits[4], func_hits[5], func_hits[6] + func_hits[7], error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/qau_pkg.sv
src/qau_front.sv
src/qau_rot.sv
src/qau_sqrt.sv
src/qau_div.sv
src/quaternion_arithmetic_unit.sv
sim/tb_quaternion_arithmetic_unit.sv
